// ===== src/bfea_pkg.sv =====
package bfea_pkg;

   // result status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_NONE = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // request actions
   localparam logic ACTION_ALLOC   = 1'b0;
   localparam logic ACTION_RELEASE = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CARVE,
      ST_INSERT,
      ST_MERGE,
      ST_DONE
   } state_type;

   // command broadcast from the sequencer to every cell
   typedef struct packed {
      logic load;      // load (0, capacity) into cell 0, clear others
      logic carve;     // carve from the selected cell
      logic remove;    // selected cell is removed, tail shifts left
      logic insert;    // insert new extent at the selected position
      logic merge;     // selected cell absorbs its right neighbor
   } cell_cmd_type;

endpackage

// ===== src/bfea_cell.sv =====
module bfea_cell
   import bfea_pkg::*;
#(
   parameter int ADDR_BITS = 32
) (
   input  logic                 clock,
   input  logic                 is_first,
   input  cell_cmd_type         cmd,
   input  logic                 sel,        // this cell is the target position
   input  logic                 after_sel,  // this cell lies right of the target
   input  logic [ADDR_BITS-1:0] cap_value,
   input  logic [ADDR_BITS-1:0] new_start,
   input  logic [ADDR_BITS-1:0] new_len,
   input  logic [ADDR_BITS-1:0] left_start,
   input  logic [ADDR_BITS-1:0] left_len,
   input  logic [ADDR_BITS-1:0] right_start,
   input  logic [ADDR_BITS-1:0] right_len,
   output logic [ADDR_BITS-1:0] start,
   output logic [ADDR_BITS-1:0] len
);

   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [ADDR_BITS-1:0] len_ff, len_in;

   // per-cell update from the broadcast command and its neighbors
   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      if (cmd.load) begin
         start_in = '0;
         len_in   = is_first ? cap_value : '0;
      end else if (cmd.carve && sel) begin
         start_in = start_ff + new_len;
         len_in   = len_ff - new_len;
      end else if (cmd.remove && (sel || after_sel)) begin
         start_in = right_start;
         len_in   = right_len;
      end else if (cmd.insert && sel) begin
         start_in = new_start;
         len_in   = new_len;
      end else if (cmd.insert && after_sel) begin
         start_in = left_start;
         len_in   = left_len;
      end else if (cmd.merge && sel) begin
         len_in = len_ff + right_len;
      end else if (cmd.merge && after_sel) begin
         // absorbed neighbor drops out, tail shifts left
         start_in = right_start;
         len_in   = right_len;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
   end

   assign start = start_ff;
   assign len   = len_ff;

endmodule

// ===== src/best_fit_extent_allocator.sv =====
// allocate scans the table for the best fit, then carves or removes it; release finds the
// insert position, inserts and merges neighbors; a zero-size or table-full release goes
// straight to the result; a new request is taken only after the previous result is given
// reset: synchronous, table holds the single extent (0, 65536), capacity 65536; busy
// stays high for one cycle after reset and after a capacity transfer
// results appear for one cycle on rsp_valid; the receiver cannot stall
module best_fit_extent_allocator
   import bfea_pkg::*;
#(
   parameter int MAX_EXTENTS = 32,
   parameter int ADDR_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_release_offset,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_granted_offset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_capacity_bytes
);

   localparam int IDX_BITS = $clog2(MAX_EXTENTS);
   localparam int CNT_BITS = $clog2(MAX_EXTENTS + 1);
   localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_EXTENTS);

   state_type state_ff, state_in;

   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  scan_ff, scan_in;      // walking index
   logic [IDX_BITS-1:0]  pos_ff, pos_in;        // chosen position
   logic                 found_ff, found_in;
   logic [ADDR_BITS-1:0] best_len_ff, best_len_in;
   logic [ADDR_BITS-1:0] best_start_ff, best_start_in;
   logic                 action_ff;
   logic [ADDR_BITS-1:0] size_ff, offset_ff;
   logic [ADDR_BITS-1:0] cap_ff;
   logic                 pending_ff, pending_in; // capacity reload waiting
   logic [1:0]           status_ff, status_in;
   logic [31:0]          grant_ff, grant_in;
   logic                 load_ff;
   logic [ADDR_BITS-1:0] req_size;

   cell_cmd_type cmd;

   logic [ADDR_BITS-1:0] cell_start [MAX_EXTENTS];
   logic [ADDR_BITS-1:0] cell_len   [MAX_EXTENTS];

   // entry under the scan pointer
   logic [IDX_BITS-1:0]  scan_idx;
   logic [IDX_BITS-1:0]  sel_pos;
   logic [ADDR_BITS-1:0] scan_start, scan_len, next_start;
   logic                 scan_in_range, pair_in_range;

   assign req_size      = ADDR_BITS'(req_request_size);
   assign scan_idx      = scan_ff[IDX_BITS-1:0];
   assign scan_start    = cell_start[scan_idx];
   assign scan_len      = cell_len[scan_idx];
   assign next_start    = (scan_idx == IDX_BITS'(MAX_EXTENTS - 1)) ? '0
                          : cell_start[scan_idx + 1'b1];
   assign scan_in_range = scan_ff < count_ff;
   assign pair_in_range = (scan_ff + 1'b1) < count_ff;

   // merge works on the entry under the scan pointer
   assign sel_pos = (state_ff == ST_MERGE) ? scan_idx : pos_ff;

   // row of cells
   for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
      logic [ADDR_BITS-1:0] ls, ll, rs, rl;
      if (g == 0) begin : g_l
         assign ls = '0;
         assign ll = '0;
      end else begin : g_l
         assign ls = cell_start[g-1];
         assign ll = cell_len[g-1];
      end
      if (g == MAX_EXTENTS - 1) begin : g_r
         assign rs = '0;
         assign rl = '0;
      end else begin : g_r
         assign rs = cell_start[g+1];
         assign rl = cell_len[g+1];
      end
      bfea_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
         .clock      (clock),
         .is_first   (g == 0),
         .cmd        (cmd),
         .sel        (sel_pos == IDX_BITS'(g)),
         .after_sel  (sel_pos < IDX_BITS'(g)),
         .cap_value  (cap_ff),
         .new_start  (offset_ff),
         .new_len    (size_ff),
         .left_start (ls),
         .left_len   (ll),
         .right_start(rs),
         .right_len  (rl),
         .start      (cell_start[g]),
         .len        (cell_len[g])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               if (req_action == ACTION_RELEASE &&
                   (req_size == '0 || count_ff >= MAX_CNT))
                  state_in = ST_DONE;
               else
                  state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (action_ff == ACTION_ALLOC) begin
               if (!scan_in_range)
                  state_in = found_ff ? ST_CARVE : ST_DONE;
            end else if (!scan_in_range ||
                         (scan_ff != '0 && !(scan_start < offset_ff))) begin
               state_in = ST_INSERT;
            end else if (scan_ff == '0 && offset_ff < scan_start) begin
               state_in = ST_INSERT;
            end
         end
         ST_CARVE:  state_in = ST_DONE;
         ST_INSERT: state_in = ST_MERGE;
         ST_MERGE:  if (!pair_in_range) state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath control and cell commands
   always_comb begin
      count_in      = count_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      pending_in    = pending_ff;
      cmd           = '0;
      cmd.load      = load_ff;
      if (load_ff) begin
         count_in   = (cap_ff != '0) ? CNT_BITS'(1) : '0;
         pending_in = 1'b0;
      end
      if (csr_valid && csr_ready)
         pending_in = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            scan_in   = '0;
            found_in  = 1'b0;
            status_in = STATUS_OK;
            grant_in  = '0;
            if (start && !busy && req_action == ACTION_RELEASE &&
                req_size != '0 && count_ff >= MAX_CNT)
               status_in = STATUS_FULL;
         end
         ST_SEARCH: begin
            if (action_ff == ACTION_ALLOC) begin
               if (scan_in_range) begin
                  if (scan_len >= size_ff && (!found_ff || scan_len < best_len_ff)) begin
                     found_in      = 1'b1;
                     best_len_in   = scan_len;
                     best_start_in = scan_start;
                     pos_in        = scan_idx;
                  end
                  scan_in = scan_ff + 1'b1;
               end else if (!found_ff) begin
                  status_in = STATUS_NONE;
               end
            end else begin
               pos_in = scan_idx;
               if (scan_in_range && (scan_ff == '0 ? !(offset_ff < scan_start)
                                                   : scan_start < offset_ff))
                  scan_in = scan_ff + 1'b1;
            end
         end
         ST_CARVE: begin
            grant_in = 32'(best_start_ff);
            if (best_len_ff == size_ff) begin
               cmd.remove = 1'b1;
               count_in   = count_ff - 1'b1;
            end else begin
               cmd.carve = 1'b1;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            count_in   = count_ff + 1'b1;
            scan_in    = '0;
         end
         ST_MERGE: begin
            pos_in = scan_idx;
            if (pair_in_range) begin
               if (scan_start + scan_len == next_start) begin
                  cmd.merge = 1'b1;
                  count_in  = count_ff - 1'b1;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         pending_ff <= 1'b0;
         load_ff    <= 1'b1;
         cap_ff     <= ADDR_BITS'(65536);
         scan_ff    <= '0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
         load_ff    <= csr_valid && csr_ready;
         if (csr_valid && csr_ready)
            cap_ff <= ADDR_BITS'(csr_capacity_bytes);
         scan_ff    <= scan_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      if (state_ff == ST_IDLE && start && !busy) begin
         action_ff <= req_action;
         size_ff   <= ADDR_BITS'(req_request_size);
         offset_ff <= ADDR_BITS'(req_release_offset);
      end
   end

   // outputs
   assign busy      = (state_ff != ST_IDLE) || pending_ff || load_ff;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_status = status_ff;
   assign rsp_granted_offset = (status_ff == STATUS_OK) ? grant_ff : '0;

   // assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("extent count overflow");
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response held two cycles");
   a_busy_work: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after start");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import bfea_pkg::*;

   localparam int TABLE_DEPTH = 32;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = ACTION_ALLOC;
   logic [31:0] req_request_size = '0;
   logic [31:0] req_release_offset = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_granted_offset;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_capacity_bytes = '0;

   // expected grant record
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] offset;
   } grant_type;

   // directed request row; check_fixed marks a typed-in expectation
   typedef struct packed {
      logic        action;
      logic [31:0] size;
      logic [31:0] offset;
      logic        check_fixed;
      logic [1:0]  fix_status;
      logic [31:0] fix_offset;
   } req_row_type;

   grant_type   pending_grants[$];
   int          error_count = 0;
   int          grant_count = 0;
   int          item_count = 0;
   int          full_count = 0;
   int          none_count = 0;
   int          merge_seen = 0;
   logic [31:0] cur_capacity;

   // shadow free-extent table
   logic [31:0] free_start[TABLE_DEPTH + 1];
   logic [31:0] free_len[TABLE_DEPTH + 1];
   int          free_count;

   best_fit_extent_allocator i_dut (.*);

   always #5 clock = ~clock;

   function automatic void shadow_load(input logic [31:0] cap);
      for (int k = 0; k < TABLE_DEPTH + 1; k++) begin
         free_start[k] = '0;
         free_len[k] = '0;
      end
      free_len[0] = cap;
      free_count = (cap != 0) ? 1 : 0;
   endfunction

   function automatic void shadow_drop(input int pos);
      for (int k = pos; k + 1 < free_count; k++) begin
         free_start[k] = free_start[k + 1];
         free_len[k] = free_len[k + 1];
      end
      free_count--;
   endfunction

   // best-fit allocate or ordered insert with coalescing
   function automatic grant_type predict_grant(input logic act, input logic [31:0] size,
                                               input logic [31:0] offset);
      grant_type g;
      int        best;
      int        pos;
      int        i;
      logic [31:0] tail;
      g = '0;
      if (act == ACTION_ALLOC) begin
         best = -1;
         for (i = 0; i < free_count; i++)
            if (free_len[i] >= size && (best < 0 || free_len[i] < free_len[best]))
               best = i;
         if (best < 0) begin
            g.status = STATUS_NONE;
         end else begin
            g.status = STATUS_OK;
            g.offset = free_start[best];
            free_start[best] = free_start[best] + size;
            free_len[best] = free_len[best] - size;
            if (free_len[best] == 0) shadow_drop(best);
         end
      end else if (size == 0) begin
         g.status = STATUS_OK;
      end else if (free_count >= TABLE_DEPTH) begin
         g.status = STATUS_FULL;
      end else begin
         g.status = STATUS_OK;
         if (free_count == 0 || offset < free_start[0]) begin
            pos = 0;
         end else begin
            pos = 1;
            while (pos < free_count && free_start[pos] < offset) pos++;
         end
         for (i = free_count; i > pos; i--) begin
            free_start[i] = free_start[i - 1];
            free_len[i] = free_len[i - 1];
         end
         free_start[pos] = offset;
         free_len[pos] = size;
         free_count++;
         i = 0;
         while (i + 1 < free_count) begin
            tail = free_start[i] + free_len[i];
            if (tail == free_start[i + 1]) begin
               free_len[i] = free_len[i] + free_len[i + 1];
               shadow_drop(i + 1);
               merge_seen++;
            end else begin
               i++;
            end
         end
      end
      return g;
   endfunction

   // compare each transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            $error("unexpected result status=%0d offset=%0h", rsp_status, rsp_granted_offset);
            error_count++;
         end else begin
            if (rsp_status !== pending_grants[0].status) begin
               $error("status expected %0d actual %0d", pending_grants[0].status, rsp_status);
               error_count++;
            end
            if (rsp_granted_offset !== pending_grants[0].offset) begin
               $error("granted_offset expected %0h actual %0h",
                      pending_grants[0].offset, rsp_granted_offset);
               error_count++;
            end
            if (pending_grants[0].status == STATUS_FULL) full_count++;
            if (pending_grants[0].status == STATUS_NONE) none_count++;
            void'(pending_grants.pop_front());
            grant_count++;
         end
      end
   end

   // optional idle burst; start drops only while idling
   task automatic sender_gap(input bit allow);
      if (allow && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // drive one request and queue its expectation at acceptance
   task automatic send_request(input logic act, input logic [31:0] size,
                               input logic [31:0] offset, input bit gaps,
                               input bit fixed, input grant_type fix);
      grant_type g;
      sender_gap(gaps);
      start <= 1'b1;
      req_action <= act;
      req_request_size <= size;
      req_release_offset <= offset;
      @(posedge clock);
      while (busy) @(posedge clock);
      g = predict_grant(act, size, offset);
      if (fixed && g !== fix) begin
         $error("table row disagrees: status expected %0d predicted %0d", fix.status, g.status);
         error_count++;
      end
      pending_grants.push_back(fixed ? fix : g);
      item_count++;
   endtask

   // wait for the block to drain, then write the capacity register
   task automatic write_capacity(input logic [31:0] cap);
      start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_valid <= 1'b1;
      csr_capacity_bytes <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_capacity = cap;
      shadow_load(cap);
   endtask

   // random phase: alloc/release mix that tracks granted blocks for real frees
   task automatic random_phase(input int count, input bit gaps);
      logic [31:0] held_off[$];
      logic [31:0] held_len[$];
      logic [31:0] size;
      logic [31:0] offset;
      int          pick;
      int          r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            // noise: any field values
            send_request(1'($urandom_range(0, 1)), $urandom(), $urandom(), gaps, 0, '0);
         end else if (r < 55 || held_off.size() == 0) begin
            case ($urandom_range(0, 3))
               0: size = $urandom_range(0, 16);
               1: size = $urandom_range(1, 4096);
               2: size = 32'(33'($urandom()) % (33'(cur_capacity) + 33'd1));
               default: size = $urandom();
            endcase
            send_request(ACTION_ALLOC, size, $urandom(), gaps, 0, '0);
            if (pending_grants[$].status == STATUS_OK && size != 0) begin
               held_off.push_back(pending_grants[$].offset);
               held_len.push_back(size);
            end
         end else begin
            // free a held block, sometimes split to make fragments
            pick = $urandom_range(0, held_off.size() - 1);
            offset = held_off[pick];
            size = held_len[pick];
            if (size > 1 && $urandom_range(0, 2) == 0) begin
               held_off[pick] = offset + size / 2;
               held_len[pick] = size - size / 2;
               size = size / 2;
            end else begin
               held_off.delete(pick);
               held_len.delete(pick);
            end
            send_request(ACTION_RELEASE, size, offset, gaps, 0, '0);
         end
      end
   endtask

   req_row_type directed_rows[$];

   function automatic req_row_type row(input logic act, input logic [31:0] size,
                                       input logic [31:0] offset, input logic fixed,
                                       input logic [1:0] st, input logic [31:0] go);
      return '{act, size, offset, fixed, st, go};
   endfunction

   initial begin
      cur_capacity = 32'd65536;
      shadow_load(cur_capacity);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table after reset
      directed_rows = '{
         row(ACTION_ALLOC, 32'd0, 32'd0, 1, STATUS_OK, 32'd0),
         row(ACTION_ALLOC, 32'd65537, 32'hffffffff, 1, STATUS_NONE, 32'd0),
         row(ACTION_ALLOC, 32'hffffffff, 32'd0, 1, STATUS_NONE, 32'd0),
         row(ACTION_ALLOC, 32'd100, 32'd0, 1, STATUS_OK, 32'd0),
         row(ACTION_ALLOC, 32'd200, 32'd0, 1, STATUS_OK, 32'd100),
         row(ACTION_ALLOC, 32'd300, 32'd0, 0, 0, 0),
         row(ACTION_RELEASE, 32'd0, 32'd5, 1, STATUS_OK, 32'd0),
         row(ACTION_RELEASE, 32'd200, 32'd100, 0, 0, 0),
         row(ACTION_ALLOC, 32'd150, 32'd0, 0, 0, 0),
         row(ACTION_RELEASE, 32'd100, 32'd0, 0, 0, 0),
         row(ACTION_RELEASE, 32'd10, 32'd0, 0, 0, 0),
         row(ACTION_RELEASE, 32'd16, 32'hfffffff0, 0, 0, 0),
         row(ACTION_ALLOC, 32'd50, 32'd0, 0, 0, 0),
         row(ACTION_ALLOC, 32'd65000, 32'd0, 0, 0, 0)
      };
      foreach (directed_rows[k])
         send_request(directed_rows[k].action, directed_rows[k].size,
                      directed_rows[k].offset, 0, directed_rows[k].check_fixed,
                      '{directed_rows[k].fix_status, directed_rows[k].fix_offset});

      // zero capacity: allocations fail until something is released
      write_capacity(32'd0);
      send_request(ACTION_ALLOC, 32'd0, 32'd0, 0, 1, '{STATUS_NONE, 32'd0});
      send_request(ACTION_ALLOC, 32'd1, 32'd0, 0, 1, '{STATUS_NONE, 32'd0});
      send_request(ACTION_RELEASE, 32'd64, 32'd1000, 0, 1, '{STATUS_OK, 32'd0});
      send_request(ACTION_ALLOC, 32'd64, 32'd0, 0, 1, '{STATUS_OK, 32'd1000});

      // fill the table with isolated fragments, then overflow it
      write_capacity(32'd1);
      for (int k = 0; k < TABLE_DEPTH; k++)
         send_request(ACTION_RELEASE, 32'd1, 32'd10 + 2 * k, 0, 0, '0);
      send_request(ACTION_RELEASE, 32'd1, 32'd11, 0, 1, '{STATUS_FULL, 32'd0});
      send_request(ACTION_RELEASE, 32'd0, 32'd11, 0, 1, '{STATUS_OK, 32'd0});

      // maximum capacity with wraparound
      write_capacity(32'hffffffff);
      send_request(ACTION_ALLOC, 32'hffffffff, 32'd0, 0, 1, '{STATUS_OK, 32'd0});
      send_request(ACTION_RELEASE, 32'hffffffff, 32'hffffffff, 0, 0, '0);
      send_request(ACTION_RELEASE, 32'd2, 32'hffffffff, 0, 0, '0);

      // random phases over several capacities
      write_capacity(32'd65536);
      random_phase(300, 1);
      // hold off until everything has come back
      start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      random_phase(100, 1);
      write_capacity(32'd4096);
      random_phase(300, 1);
      write_capacity(32'hffffffff);
      random_phase(150, 1);
      write_capacity(32'd1);
      random_phase(50, 1);
      write_capacity($urandom());
      random_phase(150, 0);

      start <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("%0d requests, %0d results; %0d table-full, %0d no-fit, %0d merges",
               item_count, grant_count, full_count, none_count, merge_seen);
      $display("capacities covered: reset, zero, one, max, small, random");
      if (error_count == 0 && pending_grants.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bfea_pkg.sv
src/bfea_cell.sv
src/best_fit_extent_allocator.sv
tb/sv/tb.sv
